/* hdl/lrcm_pkg.sv */
// Shared types, constants and helper functions for the LED rectangle coordinate mapper.
// Used by every module of the block. Depends on nothing.
package lrcm_pkg;

  localparam int IDX_W      = 12;
  localparam int SIDE_W     = 11;
  localparam int ORG_W      = 10;
  localparam int ORIENT_W   = 7;
  localparam int LEDS_W     = 13;
  localparam int AREA_W     = 2 * SIDE_W - 1;
  localparam int PIX_W      = 20;
  localparam int PROD_W     = 2 * SIDE_W;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;

  localparam int MAX_SIDE   = 1024;
  localparam int MAX_LEDS   = 4096;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = IDX_W / DIV_BITS;

  // Orientation register fields.
  localparam int ORIENT_FLIPX     = 4;
  localparam int ORIENT_FLIPY     = 5;
  localparam int ORIENT_TRANSPOSE = 6;

  localparam logic [1:0] SERP_NONE  = 2'd0;
  localparam logic [1:0] SERP_HORIZ = 2'd1;
  localparam logic [1:0] SERP_VERT  = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RECT_X       = 3'd2,
    REG_RECT_Y       = 3'd3,
    REG_RECT_WIDTH   = 3'd4,
    REG_RECT_HEIGHT  = 3'd5,
    REG_ORIENTATION  = 3'd6,
    REG_LED_COUNT    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [SIDE_W-1:0]   frame_width;
    logic [SIDE_W-1:0]   frame_height;
    logic [ORG_W-1:0]    rect_x;
    logic [ORG_W-1:0]    rect_y;
    logic [SIDE_W-1:0]   rect_width;
    logic [SIDE_W-1:0]   rect_height;
    logic [ORIENT_W-1:0] orientation;
    logic [LEDS_W-1:0]   led_count;
  } cfg_t;

  // One word in the queue between the front and the back.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             used;
  } item_t;

  function automatic logic [SIDE_W-1:0] sat_side(logic [SIDE_W-1:0] v);
    return (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
  endfunction

  function automatic logic [LEDS_W-1:0] sat_leds(logic [LEDS_W-1:0] v);
    return (v > LEDS_W'(MAX_LEDS)) ? LEDS_W'(MAX_LEDS) : v;
  endfunction

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [SIDE_W:0] div_step(logic [SIDE_W-1:0] rem, logic b,
                                               logic [SIDE_W-1:0] d);
    logic [SIDE_W-1:0] sh;
    sh = {rem[SIDE_W-2:0], b};
    if (sh >= d) begin
      return {1'b1, SIDE_W'(sh - d)};
    end
    return {1'b0, sh};
  endfunction

endpackage

/* hdl/lrcm_front.sv */
// Front end of the LED rectangle coordinate mapper: accepts LED indices and
// flags whether each one is used. Depends on lrcm_pkg.
module lrcm_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [lrcm_pkg::IDX_W-1:0] led_index,
  input  lrcm_pkg::cfg_t           cfg,
  output logic                     q_valid,
  input  logic                     q_ready,
  output lrcm_pkg::item_t          q_item
);

  logic [lrcm_pkg::SIDE_W-1:0] rw;
  logic [lrcm_pkg::SIDE_W-1:0] rh;
  logic [lrcm_pkg::LEDS_W-1:0] leds;
  logic [lrcm_pkg::AREA_W-1:0] area;
  logic [lrcm_pkg::AREA_W-1:0] limit;

  always_comb begin
    rw    = lrcm_pkg::sat_side(cfg.rect_width);
    rh    = lrcm_pkg::sat_side(cfg.rect_height);
    leds  = lrcm_pkg::sat_leds(cfg.led_count);
    area  = lrcm_pkg::AREA_W'(rw) * lrcm_pkg::AREA_W'(rh);
    limit = (area < lrcm_pkg::AREA_W'(leds)) ? area : lrcm_pkg::AREA_W'(leds);
  end

  assign in_ready    = q_ready;
  assign q_valid     = in_valid;
  assign q_item.idx  = led_index;
  assign q_item.used = (rw != '0) && (lrcm_pkg::AREA_W'(led_index) < limit);

endmodule

/* hdl/lrcm_queue.sv */
// Short first-in first-out queue that decouples the front from the back.
// Depends on lrcm_pkg.
module lrcm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lrcm_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lrcm_pkg::item_t pop_item
);

  lrcm_pkg::item_t               mem [lrcm_pkg::QUEUE_DEPTH];
  logic [lrcm_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lrcm_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lrcm_pkg::QCNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != lrcm_pkg::QCNT_W'(lrcm_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/lrcm_div.sv */
// Pipelined restoring divider that splits an LED index into row and column,
// three quotient bits per stage. Depends on lrcm_pkg.
module lrcm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  lrcm_pkg::item_t             in_item,
  input  logic [lrcm_pkg::SIDE_W-1:0] divisor,
  output logic                        out_valid,
  output logic                        out_used,
  output logic [lrcm_pkg::IDX_W-1:0]  out_quot,
  output logic [lrcm_pkg::SIDE_W-1:0] out_rem
);

  logic                        st_valid [lrcm_pkg::DIV_STAGES];
  logic                        st_used  [lrcm_pkg::DIV_STAGES];
  logic [lrcm_pkg::IDX_W-1:0]  st_dvd   [lrcm_pkg::DIV_STAGES];
  logic [lrcm_pkg::IDX_W-1:0]  st_quo   [lrcm_pkg::DIV_STAGES];
  logic [lrcm_pkg::SIDE_W-1:0] st_rem   [lrcm_pkg::DIV_STAGES];

  for (genvar s = 0; s < lrcm_pkg::DIV_STAGES; s++) begin : g_stage
    logic                        prev_valid;
    logic                        prev_used;
    logic [lrcm_pkg::IDX_W-1:0]  prev_dvd;
    logic [lrcm_pkg::IDX_W-1:0]  prev_quo;
    logic [lrcm_pkg::SIDE_W-1:0] prev_rem;
    logic [lrcm_pkg::IDX_W-1:0]  dvd_next;
    logic [lrcm_pkg::IDX_W-1:0]  quo_next;
    logic [lrcm_pkg::SIDE_W-1:0] rem_next;
    logic [lrcm_pkg::SIDE_W:0]   step;

    if (s == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev_used  = in_item.used;
      assign prev_dvd   = in_item.idx;
      assign prev_quo   = '0;
      assign prev_rem   = '0;
    end else begin : g_rest
      assign prev_valid = st_valid[s-1];
      assign prev_used  = st_used[s-1];
      assign prev_dvd   = st_dvd[s-1];
      assign prev_quo   = st_quo[s-1];
      assign prev_rem   = st_rem[s-1];
    end

    // Each step shifts the next dividend bit into the partial remainder.
    always_comb begin
      dvd_next = prev_dvd;
      quo_next = prev_quo;
      rem_next = prev_rem;
      step     = '0;
      for (int b = 0; b < lrcm_pkg::DIV_BITS; b++) begin
        step     = lrcm_pkg::div_step(rem_next, dvd_next[lrcm_pkg::IDX_W-1], divisor);
        quo_next = {quo_next[lrcm_pkg::IDX_W-2:0], step[lrcm_pkg::SIDE_W]};
        rem_next = step[lrcm_pkg::SIDE_W-1:0];
        dvd_next = {dvd_next[lrcm_pkg::IDX_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s] <= 1'b0;
      end else if (en) begin
        st_valid[s] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_used[s] <= prev_used;
        st_dvd[s]  <= dvd_next;
        st_quo[s]  <= quo_next;
        st_rem[s]  <= rem_next;
      end
    end
  end

  assign out_valid = st_valid[lrcm_pkg::DIV_STAGES-1];
  assign out_used  = st_used[lrcm_pkg::DIV_STAGES-1];
  assign out_quot  = st_quo[lrcm_pkg::DIV_STAGES-1];
  assign out_rem   = st_rem[lrcm_pkg::DIV_STAGES-1];

endmodule

/* hdl/lrcm_back.sv */
// Back end of the LED rectangle coordinate mapper: divides, transforms,
// offsets, bounds-checks and indexes each word. Depends on lrcm_pkg, lrcm_div.
module lrcm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  lrcm_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  lrcm_pkg::item_t             q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        led_used,
  output logic                        in_frame,
  output logic [lrcm_pkg::SIDE_W-1:0] source_x,
  output logic [lrcm_pkg::SIDE_W-1:0] source_y,
  output logic [lrcm_pkg::PIX_W-1:0]  pixel_index
);

  logic                        adv;
  logic [lrcm_pkg::SIDE_W-1:0] rw;
  logic [lrcm_pkg::SIDE_W-1:0] rh;
  logic [lrcm_pkg::SIDE_W-1:0] fw;
  logic [lrcm_pkg::SIDE_W-1:0] fh;

  logic                        d_valid;
  logic                        d_used;
  logic [lrcm_pkg::IDX_W-1:0]  d_quot;
  logic [lrcm_pkg::SIDE_W-1:0] d_rem;

  logic [lrcm_pkg::SIDE_W-1:0] t_row_next;
  logic [lrcm_pkg::SIDE_W-1:0] t_col_next;
  logic                        t_valid;
  logic                        t_used;
  logic [lrcm_pkg::SIDE_W-1:0] t_row;
  logic [lrcm_pkg::SIDE_W-1:0] t_col;

  logic [lrcm_pkg::SIDE_W-1:0] a_sx_next;
  logic [lrcm_pkg::SIDE_W-1:0] a_sy_next;
  logic                        a_valid;
  logic                        a_used;
  logic                        a_in;
  logic [lrcm_pkg::SIDE_W-1:0] a_sx;
  logic [lrcm_pkg::SIDE_W-1:0] a_sy;

  logic                        m_valid;
  logic                        m_used;
  logic                        m_in;
  logic [lrcm_pkg::SIDE_W-1:0] m_sx;
  logic [lrcm_pkg::SIDE_W-1:0] m_sy;
  logic [lrcm_pkg::PROD_W-1:0] m_prod;
  logic [lrcm_pkg::PROD_W-1:0] pix_sum;

  // The whole pipeline moves together whenever the output register can take a word.
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  assign rw = lrcm_pkg::sat_side(cfg.rect_width);
  assign rh = lrcm_pkg::sat_side(cfg.rect_height);
  assign fw = lrcm_pkg::sat_side(cfg.frame_width);
  assign fh = lrcm_pkg::sat_side(cfg.frame_height);

  lrcm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .divisor   (rw),
    .out_valid (d_valid),
    .out_used  (d_used),
    .out_quot  (d_quot),
    .out_rem   (d_rem)
  );

  // Serpentine, transpose, rotation and flips. For a used LED the row stays
  // below the working height and the column below the working width.
  always_comb begin
    logic [lrcm_pkg::SIDE_W-1:0] r;
    logic [lrcm_pkg::SIDE_W-1:0] c;
    logic [lrcm_pkg::SIDE_W-1:0] w;
    logic [lrcm_pkg::SIDE_W-1:0] h;
    logic [lrcm_pkg::SIDE_W-1:0] tmp;
    r   = d_quot[lrcm_pkg::SIDE_W-1:0];
    c   = d_rem;
    w   = rw;
    h   = rh;
    tmp = '0;

    if (cfg.orientation[1:0] == lrcm_pkg::SERP_HORIZ && r[0]) begin
      c = w - 1'b1 - c;
    end else if (cfg.orientation[1:0] == lrcm_pkg::SERP_VERT && c[0]) begin
      r = h - 1'b1 - r;
    end

    if (cfg.orientation[lrcm_pkg::ORIENT_TRANSPOSE]) begin
      tmp = r; r = c; c = tmp;
      tmp = w; w = h; h = tmp;
    end

    case (cfg.orientation[3:2])
      lrcm_pkg::ROT_90: begin
        tmp = c;
        c   = h - 1'b1 - r;
        r   = tmp;
        tmp = w; w = h; h = tmp;
      end
      lrcm_pkg::ROT_180: begin
        r = h - 1'b1 - r;
        c = w - 1'b1 - c;
      end
      lrcm_pkg::ROT_270: begin
        tmp = w - 1'b1 - c;
        c   = r;
        r   = tmp;
        tmp = w; w = h; h = tmp;
      end
      default: begin
      end
    endcase

    if (cfg.orientation[lrcm_pkg::ORIENT_FLIPX]) begin
      c = w - 1'b1 - c;
    end
    if (cfg.orientation[lrcm_pkg::ORIENT_FLIPY]) begin
      r = h - 1'b1 - r;
    end

    t_row_next = r;
    t_col_next = c;
  end

  assign a_sx_next = lrcm_pkg::SIDE_W'(cfg.rect_x) + t_col;
  assign a_sy_next = lrcm_pkg::SIDE_W'(cfg.rect_y) + t_row;
  assign pix_sum   = m_prod + lrcm_pkg::PROD_W'(m_sx);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid   <= 1'b0;
      a_valid   <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      t_valid   <= d_valid;
      a_valid   <= t_valid;
      m_valid   <= a_valid;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_used      <= d_used;
      t_row       <= t_row_next;
      t_col       <= t_col_next;

      a_used      <= t_used;
      a_sx        <= a_sx_next;
      a_sy        <= a_sy_next;
      a_in        <= (a_sx_next < fw) && (a_sy_next < fh);

      m_used      <= a_used;
      m_in        <= a_used && a_in;
      m_sx        <= a_sx;
      m_sy        <= a_sy;
      m_prod      <= lrcm_pkg::PROD_W'(a_sy) * lrcm_pkg::PROD_W'(fw);

      // An unused LED reports all zeros.
      led_used    <= m_used;
      in_frame    <= m_in;
      source_x    <= m_used ? m_sx : '0;
      source_y    <= m_used ? m_sy : '0;
      pixel_index <= m_in ? pix_sum[lrcm_pkg::PIX_W-1:0] : '0;
    end
  end

endmodule

/* hdl/led_rectangle_coordinate_mapper.sv */
// Top level of the LED rectangle coordinate mapper: configuration registers,
// front end, queue and back end. Depends on lrcm_pkg, lrcm_front, lrcm_queue, lrcm_back.
//
//   channel  direction  handshake               payload
//   input    in         in_valid / in_ready     led_index
//   output   out        out_valid / out_ready   led_used, in_frame, source_x,
//                                               source_y, pixel_index
//   config   in         cfg_we                  cfg_index, cfg_data
//
// One word is taken per clock while the queue has room. A word passes through the
// queue, the four divider stages, transform, offset, multiply and the output
// register, in that order.
// Synchronous reset clears config, valid flags and queue pointers; no clearing pass.
// When the output stalls, the back pipeline holds and the four-word queue fills
// before in_ready drops.
module led_rectangle_coordinate_mapper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lrcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrcm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lrcm_pkg::IDX_W-1:0]     led_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           led_used,
  output logic                           in_frame,
  output logic [lrcm_pkg::SIDE_W-1:0]    source_x,
  output logic [lrcm_pkg::SIDE_W-1:0]    source_y,
  output logic [lrcm_pkg::PIX_W-1:0]     pixel_index
);

  lrcm_pkg::cfg_t  cfg;
  logic            fq_valid;
  logic            fq_ready;
  lrcm_pkg::item_t fq_item;
  logic            qb_valid;
  logic            qb_ready;
  lrcm_pkg::item_t qb_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (lrcm_pkg::reg_index_t'(cfg_index))
        lrcm_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[lrcm_pkg::SIDE_W-1:0];
        lrcm_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[lrcm_pkg::SIDE_W-1:0];
        lrcm_pkg::REG_RECT_X:       cfg.rect_x       <= cfg_data[lrcm_pkg::ORG_W-1:0];
        lrcm_pkg::REG_RECT_Y:       cfg.rect_y       <= cfg_data[lrcm_pkg::ORG_W-1:0];
        lrcm_pkg::REG_RECT_WIDTH:   cfg.rect_width   <= cfg_data[lrcm_pkg::SIDE_W-1:0];
        lrcm_pkg::REG_RECT_HEIGHT:  cfg.rect_height  <= cfg_data[lrcm_pkg::SIDE_W-1:0];
        lrcm_pkg::REG_ORIENTATION:  cfg.orientation  <= cfg_data[lrcm_pkg::ORIENT_W-1:0];
        lrcm_pkg::REG_LED_COUNT:    cfg.led_count    <= cfg_data[lrcm_pkg::LEDS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lrcm_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .led_index (led_index),
    .cfg       (cfg),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  lrcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  lrcm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (qb_valid),
    .q_ready     (qb_ready),
    .q_item      (qb_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .led_used    (led_used),
    .in_frame    (in_frame),
    .source_x    (source_x),
    .source_y    (source_y),
    .pixel_index (pixel_index)
  );

endmodule

/* hdl/lrcm_checker.sv */
// Port-level checks for the LED rectangle coordinate mapper, bound to the top level.
// Depends on lrcm_pkg and led_rectangle_coordinate_mapper.
module lrcm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           led_used,
  input logic                           in_frame,
  input logic [lrcm_pkg::SIDE_W-1:0]    source_x,
  input logic [lrcm_pkg::SIDE_W-1:0]    source_y,
  input logic [lrcm_pkg::PIX_W-1:0]     pixel_index
);

  // An unused LED carries no coordinates at all.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !led_used |-> !in_frame && source_x == '0 && source_y == '0
                               && pixel_index == '0)
    else $error("unused LED word carries nonzero fields");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_frame |-> pixel_index == '0)
    else $error("pixel index nonzero outside the frame");

  // In-frame words come from a used LED and stay below MAX_SIDE in both coordinates.
  a_in_frame_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_frame |-> led_used && source_x < lrcm_pkg::SIDE_W'(lrcm_pkg::MAX_SIDE)
                              && source_y < lrcm_pkg::SIDE_W'(lrcm_pkg::MAX_SIDE))
    else $error("in-frame word out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(led_used) && $stable(in_frame)
                                && $stable(source_x) && $stable(source_y)
                                && $stable(pixel_index))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind led_rectangle_coordinate_mapper lrcm_checker u_lrcm_checker (.*);
